FILE: rtl/crdt_stream_merge_table_unit_macros.svh
// Assertion macros shared by the merge table unit.
`ifndef CRDT_STREAM_MERGE_TABLE_UNIT_MACROS_SVH
`define CRDT_STREAM_MERGE_TABLE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define CSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/csm_pkg.sv
// Shared types and constants for the merge table unit.
`default_nettype none
package csm_pkg;
   localparam int ENTRY_DEPTH_DEF = 64;
   localparam int ACK_DEPTH_DEF   = 64;
   localparam int TOTAL_W         = 7;
   localparam int KEY_W           = 128;
   localparam int STAMP_W         = 64;

   typedef struct packed {
      logic start;
      logic clear;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic hit;
   } stat_type;
endpackage
`default_nettype wire

FILE: rtl/csm_ctrl.sv
// Sequencer for one request: scan, commit, deliver.
`default_nettype none
module csm_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire csm_pkg::stat_type stat,
   output csm_pkg::cmd_type     cmd
);
   import csm_pkg::*;
   typedef enum logic [1:0] {IDLE, SCAN, DONE} state_type;
   state_type state_ff;
   logic      rsp_valid_ff;

   // A new request may enter once the previous result left the output register.
   assign req_ready = (state_ff == IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.start  = req_valid && req_ready;
      cmd.clear  = cmd.start;
      cmd.step   = (state_ff == SCAN) && !stat.scan_done && !stat.hit;
      cmd.commit = (state_ff == SCAN) && (stat.scan_done || stat.hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: if (cmd.start) state_ff <= SCAN;
            SCAN: if (cmd.commit) state_ff <= DONE;
            DONE: begin
               state_ff     <= IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/csm_dp.sv
// Table storage, probe pointer and merge arithmetic.
`default_nettype none
module csm_dp #(
   parameter int ENTRY_DEPTH = csm_pkg::ENTRY_DEPTH_DEF,
   parameter int ACK_DEPTH   = csm_pkg::ACK_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire csm_pkg::cmd_type     cmd,
   output csm_pkg::stat_type         stat,
   input  wire logic                 req_mode,
   input  wire logic [63:0]          req_id_ms,
   input  wire logic [31:0]          req_id_origin,
   input  wire logic [31:0]          req_id_seq,
   input  wire logic                 req_is_deleted,
   input  wire logic [63:0]          req_delete_stamp,
   input  wire logic [63:0]          req_ack_stamp,
   output logic                      rsp_changed,
   output logic                      rsp_status,
   output logic [6:0]                rsp_entry_total,
   output logic [63:0]               rsp_top_ms,
   output logic [31:0]               rsp_top_origin,
   output logic [31:0]               rsp_top_seq
);
   import csm_pkg::*;
   localparam int MAXD = (ENTRY_DEPTH > ACK_DEPTH) ? ENTRY_DEPTH : ACK_DEPTH;
   localparam int PW   = $clog2(MAXD + 1);
   localparam int EW   = $clog2(ENTRY_DEPTH);
   localparam int AW   = $clog2(ACK_DEPTH);
   localparam int CW   = $clog2(ENTRY_DEPTH + 1);

   logic [KEY_W-1:0]   ekey_mem [ENTRY_DEPTH];
   logic [STAMP_W:0]   etomb_mem [ENTRY_DEPTH];
   logic [KEY_W-1:0]   akey_mem [ACK_DEPTH];
   logic [STAMP_W-1:0] alat_mem [ACK_DEPTH];
   logic [ENTRY_DEPTH-1:0] evalid_ff;
   logic [ACK_DEPTH-1:0]   avalid_ff;

   logic               mode_ff, del_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [STAMP_W-1:0] dstamp_ff, astamp_ff;
   logic [PW-1:0]      ptr_ff;
   logic               free_found_ff;
   logic [PW-1:0]      free_ff;
   logic               rd_ok_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [STAMP_W:0]   rd_data_ff;
   logic               rd_valid_ff;
   logic [CW-1:0]      count_ff;
   logic [KEY_W-1:0]   top_ff;
   logic               changed_ff;
   logic               status_ff;

   logic [PW-1:0] depth;
   logic          hit_now, full_now;
   assign depth = mode_ff ? PW'(ACK_DEPTH) : PW'(ENTRY_DEPTH);
   assign hit_now = rd_ok_ff && rd_valid_ff && (rd_key_ff == key_ff);

   // The probe reads one slot a cycle; compare happens on the registered read.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff   <= req_mode;
         del_ff    <= req_is_deleted;
         key_ff    <= {req_id_ms, req_id_origin, req_id_seq};
         dstamp_ff <= req_delete_stamp;
         astamp_ff <= req_ack_stamp;
      end
      if (cmd.start || cmd.step) begin
         rd_ptr_ff <= cmd.start ? '0 : ptr_ff;
      end
      if (!mode_ff) begin
         rd_key_ff   <= ekey_mem[ptr_ff[EW-1:0]];
         rd_data_ff  <= etomb_mem[ptr_ff[EW-1:0]];
      end else begin
         rd_key_ff   <= akey_mem[ptr_ff[AW-1:0]];
         rd_data_ff  <= {1'b0, alat_mem[ptr_ff[AW-1:0]]};
      end
      rd_valid_ff <= mode_ff ? avalid_ff[ptr_ff[AW-1:0]] : evalid_ff[ptr_ff[EW-1:0]];
   end

   assign stat.hit       = hit_now;
   assign stat.scan_done = rd_ok_ff && (rd_ptr_ff == depth - PW'(1));
   assign full_now       = !free_found_ff && !(rd_ok_ff && !rd_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         evalid_ff <= '0;
         avalid_ff <= '0;
         count_ff  <= '0;
         top_ff    <= '0;
         rd_ok_ff  <= 1'b0;
         ptr_ff    <= '0;
         free_found_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            ptr_ff        <= '0;
            rd_ok_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (cmd.step || (!rd_ok_ff && !cmd.commit)) begin
            if (ptr_ff < depth) ptr_ff <= ptr_ff + PW'(1);
            rd_ok_ff <= (ptr_ff < depth);
            if (rd_ok_ff && !rd_valid_ff && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_ff       <= rd_ptr_ff;
            end
         end
         if (cmd.commit) begin
            rd_ok_ff <= 1'b0;
            changed_ff <= 1'b0;
            status_ff  <= 1'b0;
            if (hit_now) begin
               if (!mode_ff) begin
                  if (del_ff && (!rd_data_ff[STAMP_W] ||
                                 dstamp_ff > rd_data_ff[STAMP_W-1:0])) begin
                     etomb_mem[rd_ptr_ff[EW-1:0]] <= {1'b1, dstamp_ff};
                     changed_ff <= 1'b1;
                  end
               end else if (astamp_ff > rd_data_ff[STAMP_W-1:0]) begin
                  alat_mem[rd_ptr_ff[AW-1:0]] <= astamp_ff;
                  changed_ff <= 1'b1;
               end
            end else if (full_now) begin
               status_ff <= 1'b1;
            end else begin
               logic [PW-1:0] slot;
               slot = free_found_ff ? free_ff : rd_ptr_ff;
               changed_ff <= 1'b1;
               if (!mode_ff) begin
                  evalid_ff[slot[EW-1:0]] <= 1'b1;
                  ekey_mem[slot[EW-1:0]]  <= key_ff;
                  etomb_mem[slot[EW-1:0]] <= del_ff ? {1'b1, dstamp_ff} : '0;
                  count_ff <= count_ff + CW'(1);
                  if (key_ff > top_ff) top_ff <= key_ff;
               end else begin
                  avalid_ff[slot[AW-1:0]] <= 1'b1;
                  akey_mem[slot[AW-1:0]]  <= key_ff;
                  alat_mem[slot[AW-1:0]]  <= astamp_ff;
               end
            end
         end
      end
   end

   assign rsp_changed     = changed_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_total = TOTAL_W'(count_ff);
   assign rsp_top_ms      = top_ff[127:64];
   assign rsp_top_origin  = top_ff[63:32];
   assign rsp_top_seq     = top_ff[31:0];
endmodule
`default_nettype wire

FILE: rtl/crdt_stream_merge_table_unit.sv
// Top level: CRDT stream merge table with scan sequencer and datapath.
// Sequence: a taken request scans the table slot by slot until the matching key
// or the last slot, commits, passes the DONE state, then raises rsp_valid.
// The next request is taken only once the receiver has taken the result, so
// one request is in flight at a time.
// Reset (synchronous, active high) clears valid bits, count and greatest id.
`default_nettype none
`include "crdt_stream_merge_table_unit_macros.svh"
module crdt_stream_merge_table_unit #(
   parameter int ENTRY_DEPTH = csm_pkg::ENTRY_DEPTH_DEF,
   parameter int ACK_DEPTH   = csm_pkg::ACK_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [63:0] req_id_ms,
   input  wire logic [31:0] req_id_origin,
   input  wire logic [31:0] req_id_seq,
   input  wire logic        req_is_deleted,
   input  wire logic [63:0] req_delete_stamp,
   input  wire logic [63:0] req_ack_stamp,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_changed,
   output logic             rsp_status,
   output logic [6:0]       rsp_entry_total,
   output logic [63:0]      rsp_top_ms,
   output logic [31:0]      rsp_top_origin,
   output logic [31:0]      rsp_top_seq
);
   import csm_pkg::*;
   cmd_type  cmd;
   stat_type stat;

   csm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   csm_dp #(.ENTRY_DEPTH(ENTRY_DEPTH), .ACK_DEPTH(ACK_DEPTH)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_mode, .req_id_ms, .req_id_origin, .req_id_seq,
      .req_is_deleted, .req_delete_stamp, .req_ack_stamp,
      .rsp_changed, .rsp_status, .rsp_entry_total,
      .rsp_top_ms, .rsp_top_origin, .rsp_top_seq
   );

   `CSM_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready, "request taken while result pending")
   `CSM_ASSERT_IMP(a_drop_no_change, clock, reset, rsp_valid, !(rsp_changed && rsp_status), "dropped request reports change")
   `CSM_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready, "port open right after accept")
endmodule
`default_nettype wire

FILE: dv/tb.sv
// Testbench for the stream merge table unit with a scoreboard class, directed requests and random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   localparam int DEPTH = 64;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic        changed;
      logic        status;
      logic [6:0]  total;
      logic [63:0] top_ms;
      logic [31:0] top_origin;
      logic [31:0] top_seq;
   } merge_rsp_type;

   typedef struct packed {
      logic        mode;
      logic [63:0] ms;
      logic [31:0] origin;
      logic [31:0] seq;
      logic        del;
      logic [63:0] dstamp;
      logic [63:0] astamp;
   } merge_req_type;

   int errors = 0;
   int checked = 0;

   task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
   endtask

   class merge_scoreboard;
      logic [127:0] ekey[DEPTH];
      bit           evalid[DEPTH];
      bit           etomb[DEPTH];
      logic [63:0]  estamp[DEPTH];
      logic [127:0] akey[DEPTH];
      bit           avalid[DEPTH];
      logic [63:0]  alatest[DEPTH];
      logic [6:0]   count;
      logic [127:0] top;
      merge_rsp_type pending[$];

      function new();
         foreach (evalid[i]) begin
            evalid[i] = 0;
            avalid[i] = 0;
         end
         count = 0;
         top = '0;
      endfunction

      function void note_request(merge_req_type r);
         logic [127:0] k;
         int           slot;
         bit           chg, full, hit;
         merge_rsp_type e;
         k = {r.ms, r.origin, r.seq};
         slot = -1;
         chg = 0;
         full = 0;
         hit = 0;
         if (!r.mode) begin
            for (int i = 0; i < DEPTH && !hit; i++) begin
               if (evalid[i]) begin
                  if (ekey[i] == k) begin
                     hit = 1;
                     if (r.del && (!etomb[i] || r.dstamp > estamp[i])) begin
                        etomb[i] = 1;
                        estamp[i] = r.dstamp;
                        chg = 1;
                     end
                  end
               end else if (slot < 0) begin
                  slot = i;
               end
            end
            if (!hit) begin
               if (slot < 0) begin
                  full = 1;
               end else begin
                  evalid[slot] = 1;
                  ekey[slot] = k;
                  etomb[slot] = r.del;
                  estamp[slot] = r.del ? r.dstamp : 64'd0;
                  count++;
                  if (k > top) top = k;
                  chg = 1;
               end
            end
         end else begin
            for (int i = 0; i < DEPTH && !hit; i++) begin
               if (avalid[i]) begin
                  if (akey[i] == k) begin
                     hit = 1;
                     if (r.astamp > alatest[i]) begin
                        alatest[i] = r.astamp;
                        chg = 1;
                     end
                  end
               end else if (slot < 0) begin
                  slot = i;
               end
            end
            if (!hit) begin
               if (slot < 0) begin
                  full = 1;
               end else begin
                  avalid[slot] = 1;
                  akey[slot] = k;
                  alatest[slot] = r.astamp;
                  chg = 1;
               end
            end
         end
         e.changed = chg;
         e.status = full;
         e.total = count;
         {e.top_ms, e.top_origin, e.top_seq} = top;
         pending.push_back(e);
      endfunction

      task check_result(merge_rsp_type g);
         merge_rsp_type w;
         if (pending.size() == 0) begin
            report("unexpected response", 0, 0);
            return;
         end
         w = pending.pop_front();
         checked++;
         if (g.changed !== w.changed) report("changed", g.changed, w.changed);
         if (g.status !== w.status) report("status", g.status, w.status);
         if (g.total !== w.total) report("entry_total", g.total, w.total);
         if (g.top_ms !== w.top_ms) report("top_ms", g.top_ms, w.top_ms);
         if (g.top_origin !== w.top_origin) report("top_origin", g.top_origin, w.top_origin);
         if (g.top_seq !== w.top_seq) report("top_seq", g.top_seq, w.top_seq);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_mode = 0;
   logic [63:0] req_id_ms = 0;
   logic [31:0] req_id_origin = 0;
   logic [31:0] req_id_seq = 0;
   logic        req_is_deleted = 0;
   logic [63:0] req_delete_stamp = 0;
   logic [63:0] req_ack_stamp = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_changed, rsp_status;
   logic [6:0]  rsp_entry_total;
   logic [63:0] rsp_top_ms;
   logic [31:0] rsp_top_origin, rsp_top_seq;

   crdt_stream_merge_table_unit dut (.*);

   always #1 clock = ~clock;

   merge_scoreboard sb = new();
   int  cycles = 0;
   bit  quiet = 0;
   bit  hold_rsp = 0;
   int  sent = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_changed, rsp_status, rsp_entry_total,
                          rsp_top_ms, rsp_top_origin, rsp_top_seq});
   end

   // Response side: random stall bursts, a long hold when asked, none near the end.
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // Valid stays up after an accept until the next request or an idle stretch replaces it.
   task automatic send(input merge_req_type r);
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= r.mode;
      req_id_ms <= r.ms;
      req_id_origin <= r.origin;
      req_id_seq <= r.seq;
      req_is_deleted <= r.del;
      req_delete_stamp <= r.dstamp;
      req_ack_stamp <= r.astamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(r);
      sent++;
   endtask

   function automatic logic [63:0] rnd64();
      return {$urandom(), $urandom()};
   endfunction

   // Ids are drawn from a small pool so that hits, tombstone races and full tables happen.
   function automatic merge_req_type pick(input int pool);
      merge_req_type r;
      int         k;
      k = $urandom_range(0, pool - 1);
      r.mode = 1'($urandom_range(0, 1));
      r.ms = ($urandom_range(0, 7) == 0) ? rnd64() : 64'(k / 9);
      r.origin = ($urandom_range(0, 7) == 0) ? $urandom() : 32'((k / 3) % 3);
      r.seq = ($urandom_range(0, 7) == 0) ? $urandom() : 32'(k % 3);
      r.del = 1'($urandom_range(0, 1));
      r.dstamp = ($urandom_range(0, 1)) ? 64'($urandom_range(0, 4)) : rnd64();
      r.astamp = ($urandom_range(0, 1)) ? 64'($urandom_range(0, 4)) : rnd64();
      return r;
   endfunction

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, live then tombstone updates, equal stamps, acks.
      send('{0, '1, '1, '1, 0, '1, '1});
      send('{0, '1, '1, '1, 0, 0, 0});
      send('{0, '1, '1, '1, 1, 64'd5, 0});
      send('{0, '1, '1, '1, 1, 64'd5, 0});
      send('{0, '1, '1, '1, 1, 64'd4, 0});
      send('{0, '1, '1, '1, 1, '1, 0});
      send('{0, 0, 0, 0, 1, 64'd7, '1});
      send('{0, 0, 0, 0, 0, 0, 0});
      send('{0, 64'd1, 0, 0, 0, 0, 0});
      send('{0, 64'd1, '1, 0, 0, 0, 0});
      send('{0, 64'd1, '1, 32'd1, 0, 0, 0});
      send('{1, '1, '1, '1, 1, '1, 64'd3});
      send('{1, '1, '1, '1, 0, 0, 64'd3});
      send('{1, '1, '1, '1, 0, 0, 64'd2});
      send('{1, '1, '1, '1, 0, 0, '1});
      send('{1, 0, 0, 0, 0, 0, 0});
      drain();

      // Fill the response path while requests keep coming.
      hold_rsp = 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         for (int i = 0; i < 20; i++) send(pick(200));
      join
      drain();

      for (int i = 0; i < 1660; i++) begin
         if (i == 1500) quiet = 1;
         send(pick(i < 800 ? 60 : 250));
         if (i == 700) drain();
      end
      drain();
      repeat (3 * DEPTH + 20) @(posedge clock);

      $display("sent %0d requests, checked %0d responses; tables filled to %0d entries",
               sent, checked, sb.count);
      if (errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
